// ----- rtl/mbwb_pkg.sv -----
package mbwb_pkg;

  localparam logic [15:0] CMD_COLUMN_ADDR = 16'd42;
  localparam logic [15:0] CMD_PAGE_ADDR   = 16'd43;
  localparam logic [15:0] CMD_MEM_WRITE   = 16'd44;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X       = 3'd0,
    CFG_POS_Y       = 3'd1,
    CFG_IMG_WIDTH   = 3'd2,
    CFG_IMG_HEIGHT  = 3'd3,
    CFG_FORE_COLOR  = 3'd4,
    CFG_BACK_COLOR  = 3'd5,
    CFG_CENTER_MODE = 3'd6
  } cfg_idx_t;

  localparam logic [3:0] WINDOW_WORDS = 4'd7;
  localparam logic [3:0] PIXELS_PER_BYTE = 4'd8;

  // One queued job: either a window sequence or the expansion of one byte.
  typedef struct packed {
    logic        is_window;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [7:0]  bits;
    logic [15:0] fore;
    logic [15:0] back;
    logic [3:0]  cnt;
    logic        done;
  } job_t;

endpackage

// ----- rtl/mbwb_in_if.sv -----
interface mbwb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] bitmap_byte;

  modport source (output valid, output opcode, output bitmap_byte, input ready);
  modport sink (input valid, input opcode, input bitmap_byte, output ready);
endinterface

// ----- rtl/mbwb_out_if.sv -----
interface mbwb_out_if;
  logic        valid;
  logic        ready;
  logic        is_command;
  logic [15:0] out_word;
  logic        run_last;
  logic        frame_done;

  modport source (output valid, output is_command, output out_word, output run_last,
                  output frame_done, input ready);
  modport sink (input valid, input is_command, input out_word, input run_last,
                input frame_done, output ready);
endinterface

// ----- rtl/mbwb_cfg_if.sv -----
interface mbwb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mbwb_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mono_bitmap_window_blitter.sv -----
// Monochrome bitmap window blitter.
// in_ch takes items: opcode START computes the drawing window from the
// position, size and centering registers and queues the seven-word window
// sequence; opcode BYTE expands one bitmap byte, MSB first, into up to eight
// RGB565 words (fewer at a row end). Bytes with no frame running are dropped.
// cfg_ch writes the seven registers by index; it is always ready and should
// only be used while the block is idle.
// out_ch delivers one word per transfer with is_command, run_last and
// frame_done flags.
// With the queue and the output register empty, the first word of an item
// passes through the job queue and then the output register before it is valid.
// The output register moves one word per cycle while the receiver is ready;
// a START gives seven words and a byte one to eight (eight in the middle of
// a row). The front accepts a new item whenever the job queue between front
// and back has room, so items overlap with words still going out.
// When the receiver stalls, the output word holds, the queue fills and then
// in_ch.ready drops. Reset clears the registers, the frame state and the
// queue; no frame is active afterwards.
module mono_bitmap_window_blitter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  mbwb_in_if.sink    in_ch,
  mbwb_cfg_if.sink   cfg_ch,
  mbwb_out_if.source out_ch
);

  logic           q_full, q_push, q_pop, q_head_valid;
  mbwb_pkg::job_t q_job, q_head;

  mbwb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  mbwb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  mbwb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/mbwb_front.sv -----
module mbwb_front (
  input  logic            clk,
  input  logic            rst_n,
  mbwb_in_if.sink         in_ch,
  mbwb_cfg_if.sink        cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output mbwb_pkg::job_t  q_job
);

  logic [15:0] pos_x_r, pos_y_r, img_width_r, img_height_r, fore_r, back_r;
  logic        center_r;

  logic [15:0] frame_w_r, frame_h_r, row_r, col_r;
  logic [15:0] frame_w_nxt, frame_h_nxt, row_nxt, col_nxt;
  logic        active_r, active_nxt;

  logic        accept;
  logic [15:0] x0, x1, y0, y1;
  logic        empty;
  logic [16:0] left;
  logic        row_end, done;
  logic [3:0]  n;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      img_width_r  <= '0;
      img_height_r <= '0;
      fore_r       <= '0;
      back_r       <= '0;
      center_r     <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        mbwb_pkg::CFG_POS_X:       pos_x_r      <= cfg_ch.data;
        mbwb_pkg::CFG_POS_Y:       pos_y_r      <= cfg_ch.data;
        mbwb_pkg::CFG_IMG_WIDTH:   img_width_r  <= cfg_ch.data;
        mbwb_pkg::CFG_IMG_HEIGHT:  img_height_r <= cfg_ch.data;
        mbwb_pkg::CFG_FORE_COLOR:  fore_r       <= cfg_ch.data;
        mbwb_pkg::CFG_BACK_COLOR:  back_r       <= cfg_ch.data;
        mbwb_pkg::CFG_CENTER_MODE: center_r     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Window span; an even length in centered mode loses one pixel at the high end.
  always_comb begin
    if (center_r) begin
      x0 = pos_x_r - {1'b0, img_width_r[15:1]};
      x1 = pos_x_r + {1'b0, img_width_r[15:1]} - {15'd0, !img_width_r[0]};
      y0 = pos_y_r - {1'b0, img_height_r[15:1]};
      y1 = pos_y_r + {1'b0, img_height_r[15:1]} - {15'd0, !img_height_r[0]};
    end else begin
      x0 = pos_x_r;
      x1 = pos_x_r + img_width_r - 16'd1;
      y0 = pos_y_r;
      y1 = pos_y_r + img_height_r - 16'd1;
    end
  end

  assign empty   = (img_width_r == 16'd0) || (img_height_r == 16'd0);
  assign left    = {1'b0, frame_w_r} - {1'b0, col_r};
  assign row_end = (left <= 17'd8);
  assign n       = row_end ? left[3:0] : mbwb_pkg::PIXELS_PER_BYTE;
  assign done    = row_end && (({1'b0, row_r} + 17'd1) >= {1'b0, frame_h_r});

  always_comb begin
    q_job.is_window = (in_ch.opcode == mbwb_pkg::OP_START);
    q_job.x0        = x0;
    q_job.x1        = x1;
    q_job.y0        = y0;
    q_job.y1        = y1;
    q_job.bits      = in_ch.bitmap_byte;
    q_job.fore      = fore_r;
    q_job.back      = back_r;
    q_job.cnt       = q_job.is_window ? mbwb_pkg::WINDOW_WORDS : n;
    q_job.done      = q_job.is_window ? empty : done;
  end

  // A byte that arrives with no frame running is dropped here.
  assign q_push = accept && ((in_ch.opcode == mbwb_pkg::OP_START) || active_r);

  always_comb begin
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    active_nxt  = active_r;
    if (accept) begin
      if (in_ch.opcode == mbwb_pkg::OP_START) begin
        frame_w_nxt = img_width_r;
        frame_h_nxt = img_height_r;
        row_nxt     = '0;
        col_nxt     = '0;
        active_nxt  = !empty;
      end else if (active_r) begin
        if (row_end) begin
          col_nxt = '0;
          if (done) begin
            row_nxt    = '0;
            active_nxt = 1'b0;
          end else begin
            row_nxt = row_r + 16'd1;
          end
        end else begin
          col_nxt = col_r + 16'd8;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= '0;
      frame_h_r <= '0;
      row_r     <= '0;
      col_r     <= '0;
      active_r  <= 1'b0;
    end else begin
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      active_r  <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (frame_w_r != 16'd0) && (frame_h_r != 16'd0) && (col_r < frame_w_r))
    else $error("active frame with empty size or column past the row end");
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (row_r == 16'd0) && (col_r == 16'd0))
    else $error("counters not cleared while no frame runs");
`endif

endmodule

// ----- rtl/mbwb_fifo.sv -----
module mbwb_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbwb_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mbwb_pkg::job_t  head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mbwb_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above its depth");
`endif

endmodule

// ----- rtl/mbwb_back.sv -----
module mbwb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  mbwb_pkg::job_t  head_job,
  output logic            pop,
  mbwb_out_if.source      out_ch
);

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic        cmd_r, last_r, done_r;
  logic [15:0] word_r;

  logic        advance, last;
  logic        word_cmd;
  logic [15:0] word;

  assign advance = head_valid && (!valid_r || out_ch.ready);
  assign last    = ({1'b0, idx_r} + 4'd1) == head_job.cnt;
  assign pop     = advance && last;

  always_comb begin
    word_cmd = 1'b0;
    word     = '0;
    if (head_job.is_window) begin
      unique case (idx_r)
        3'd0: begin word_cmd = 1'b1; word = mbwb_pkg::CMD_COLUMN_ADDR; end
        3'd1: word = head_job.x0;
        3'd2: word = head_job.x1;
        3'd3: begin word_cmd = 1'b1; word = mbwb_pkg::CMD_PAGE_ADDR; end
        3'd4: word = head_job.y0;
        3'd5: word = head_job.y1;
        default: begin word_cmd = 1'b1; word = mbwb_pkg::CMD_MEM_WRITE; end
      endcase
    end else begin
      // Pixels go out most significant bit first.
      word = head_job.bits[3'd7 - idx_r] ? head_job.fore : head_job.back;
    end
  end

  assign idx_nxt   = advance ? (last ? 3'd0 : idx_r + 3'd1) : idx_r;
  assign valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    if (advance) begin
      cmd_r  <= word_cmd;
      word_r <= word;
      last_r <= last;
      done_r <= last && head_job.done;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.is_command = cmd_r;
  assign out_ch.out_word   = word_r;
  assign out_ch.run_last   = last_r;
  assign out_ch.frame_done = done_r;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && done_r |-> last_r)
    else $error("frame done flagged on a word that does not end its item");
  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && cmd_r |-> (word_r == mbwb_pkg::CMD_COLUMN_ADDR) ||
                         (word_r == mbwb_pkg::CMD_PAGE_ADDR) ||
                         (word_r == mbwb_pkg::CMD_MEM_WRITE))
    else $error("command flag on a word that is no command code");
`endif

endmodule

// ----- bench/tb_mono_bitmap_window_blitter.sv -----
`timescale 1ns / 1ps

module tb_mono_bitmap_window_blitter;

  localparam int RAND_ITEMS  = 240;
  localparam int SETTLE      = 6;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic        is_cmd;
    logic [15:0] word;
    logic        last;
    logic        done;
  } blit_word_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    mbwb_pkg::cfg_idx_t idx;
    logic [15:0]        val;
    logic               op;
    logic [7:0]         bits;
    logic               typed;
    logic [3:0]         n;
    logic               done;
    logic [0:7][15:0]   w;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mbwb_in_if  in_ch ();
  mbwb_out_if out_ch ();
  mbwb_cfg_if cfg_ch ();

  mono_bitmap_window_blitter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the block: registers and frame state.
  logic [15:0] m_pos_x = '0, m_pos_y = '0, m_width = '0, m_height = '0;
  logic [15:0] m_fore = '0, m_back = '0;
  logic        m_center = 1'b0;
  logic [15:0] m_row = '0, m_col = '0, m_frame_w = '0, m_frame_h = '0;
  logic        m_active = 1'b0;

  blit_word_t fresh_words[$];
  blit_word_t pending_words[$];
  plan_row_t  plan[$];

  int   errors = 0;
  int   stuck = 0;
  int   drv_row = -1;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void win_span(input logic [15:0] p, input logic [15:0] len,
                                   output logic [15:0] lo, output logic [15:0] hi);
    logic [15:0] half;
    if (m_center) begin
      half = len >> 1;
      lo = p - half;
      hi = p + half;
      if (!len[0]) hi = hi - 16'd1;
    end else begin
      lo = p;
      hi = p + len - 16'd1;
    end
  endfunction

  function automatic void push_word(logic c, logic [15:0] v, logic l, logic d);
    fresh_words.push_back({c, v, l, d});
  endfunction

  function automatic void blit_predict(logic op, logic [7:0] bits);
    logic [15:0] x0, x1, y0, y1;
    int left, n, k;
    logic row_end, done;
    if (op == mbwb_pkg::OP_START) begin
      win_span(m_pos_x, m_width, x0, x1);
      win_span(m_pos_y, m_height, y0, y1);
      m_frame_w = m_width;
      m_frame_h = m_height;
      m_row = '0;
      m_col = '0;
      done = (m_width == 16'd0) || (m_height == 16'd0);
      m_active = !done;
      push_word(1'b1, mbwb_pkg::CMD_COLUMN_ADDR, 1'b0, 1'b0);
      push_word(1'b0, x0, 1'b0, 1'b0);
      push_word(1'b0, x1, 1'b0, 1'b0);
      push_word(1'b1, mbwb_pkg::CMD_PAGE_ADDR, 1'b0, 1'b0);
      push_word(1'b0, y0, 1'b0, 1'b0);
      push_word(1'b0, y1, 1'b0, 1'b0);
      push_word(1'b1, mbwb_pkg::CMD_MEM_WRITE, 1'b1, done);
    end else if (m_active) begin
      left = int'(m_frame_w) - int'(m_col);
      n = (left < 8) ? left : 8;
      row_end = (left <= 8);
      done = row_end && (int'(m_row) + 1 >= int'(m_frame_h));
      for (k = 0; k < n; k++)
        push_word(1'b0, bits[7-k] ? m_fore : m_back, k == n - 1, (k == n - 1) && done);
      if (row_end) begin
        m_col = '0;
        m_row = m_row + 16'd1;
        if (done) begin
          m_active = 1'b0;
          m_row = '0;
        end
      end else begin
        m_col = m_col + 16'd8;
      end
    end
  endfunction

  function automatic void reg_write(mbwb_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      mbwb_pkg::CFG_POS_X:       m_pos_x = v;
      mbwb_pkg::CFG_POS_Y:       m_pos_y = v;
      mbwb_pkg::CFG_IMG_WIDTH:   m_width = v;
      mbwb_pkg::CFG_IMG_HEIGHT:  m_height = v;
      mbwb_pkg::CFG_FORE_COLOR:  m_fore = v;
      mbwb_pkg::CFG_BACK_COLOR:  m_back = v;
      mbwb_pkg::CFG_CENTER_MODE: m_center = v[0];
      default: ;
    endcase
  endfunction

  task automatic check_word(blit_word_t e);
    if (out_ch.is_command !== e.is_cmd) begin
      $error("is_command: expected %0b, got %0b", e.is_cmd, out_ch.is_command);
      errors++;
    end
    if (out_ch.out_word !== e.word) begin
      $error("out_word: expected %h, got %h", e.word, out_ch.out_word);
      errors++;
    end
    if (out_ch.run_last !== e.last) begin
      $error("run_last: expected %0b, got %0b", e.last, out_ch.run_last);
      errors++;
    end
    if (out_ch.frame_done !== e.done) begin
      $error("frame_done: expected %0b, got %0b", e.done, out_ch.frame_done);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    blit_word_t w;
    int k;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        fresh_words.delete();
        blit_predict(in_ch.opcode, in_ch.bitmap_byte);
        // Rows with typed-in results replace the predicted words.
        if (drv_row >= 0 && plan[drv_row].typed) begin
          fresh_words.delete();
          for (k = 0; k < int'(plan[drv_row].n); k++) begin
            w.is_cmd = (plan[drv_row].op == mbwb_pkg::OP_START) && (k % 3 == 0);
            w.word = plan[drv_row].w[k];
            w.last = (k == int'(plan[drv_row].n) - 1);
            w.done = w.last && plan[drv_row].done;
            fresh_words.push_back(w);
          end
        end
        while (fresh_words.size() > 0) pending_words.push_back(fresh_words.pop_front());
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        reg_write(mbwb_pkg::cfg_idx_t'(cfg_ch.index), cfg_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_words.size() == 0) begin
          $error("out_word %h arrived with no expected word pending", out_ch.out_word);
          errors++;
        end else begin
          check_word(pending_words.pop_front());
        end
      end
    end
    if (moved) stuck = 0;
    else stuck++;
    if (stuck >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_item(logic op, logic [7:0] bits, int row);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.bitmap_byte <= bits;
    drv_row <= row;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic cfg_write(mbwb_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic add_cfg(mbwb_pkg::cfg_idx_t idx, logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endtask

  task automatic add_item(logic op, logic [7:0] bits);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.bits = bits;
    plan.push_back(r);
  endtask

  task automatic add_typed(logic op, logic [7:0] bits, logic [3:0] n, logic done,
                           logic [0:7][15:0] w);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.bits = bits;
    r.typed = 1'b1;
    r.n = n;
    r.done = done;
    r.w = w;
    plan.push_back(r);
  endtask

  initial begin
    int i, k, w, h, sel, r, nbytes, restart_at, n_items, phase;
    logic center, fill;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = mbwb_pkg::OP_START;
    in_ch.bitmap_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mbwb_pkg::CFG_POS_X;
    cfg_ch.data = 16'h0000;

    // Right after reset: idle byte, empty corner window, idle byte again.
    add_typed(mbwb_pkg::OP_BYTE, 8'hA5, 4'd0, 1'b0, '0);
    add_typed(mbwb_pkg::OP_START, 8'h00, 4'd7, 1'b1,
              {mbwb_pkg::CMD_COLUMN_ADDR, 16'h0000, 16'hFFFF,
               mbwb_pkg::CMD_PAGE_ADDR, 16'h0000, 16'hFFFF,
               mbwb_pkg::CMD_MEM_WRITE, 16'h0000});
    add_typed(mbwb_pkg::OP_BYTE, 8'hFF, 4'd0, 1'b0, '0);
    // Corner window at the top of the range wraps past zero.
    add_cfg(mbwb_pkg::CFG_POS_X, 16'hFFFF);
    add_cfg(mbwb_pkg::CFG_POS_Y, 16'hFFFF);
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'd8);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'd2);
    add_cfg(mbwb_pkg::CFG_FORE_COLOR, 16'hFFFF);
    add_cfg(mbwb_pkg::CFG_BACK_COLOR, 16'h0000);
    add_typed(mbwb_pkg::OP_START, 8'h00, 4'd7, 1'b0,
              {mbwb_pkg::CMD_COLUMN_ADDR, 16'hFFFF, 16'h0006,
               mbwb_pkg::CMD_PAGE_ADDR, 16'hFFFF, 16'h0000,
               mbwb_pkg::CMD_MEM_WRITE, 16'h0000});
    add_typed(mbwb_pkg::OP_BYTE, 8'hFF, 4'd8, 1'b0, {8{16'hFFFF}});
    add_typed(mbwb_pkg::OP_BYTE, 8'h00, 4'd8, 1'b1, {8{16'h0000}});
    add_typed(mbwb_pkg::OP_BYTE, 8'h5A, 4'd0, 1'b0, '0);
    // Centered, odd width; width and foreground color rewritten while the frame runs.
    add_cfg(mbwb_pkg::CFG_CENTER_MODE, 16'd1);
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'd3);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'd4);
    add_cfg(mbwb_pkg::CFG_POS_X, 16'd0);
    add_cfg(mbwb_pkg::CFG_POS_Y, 16'd1);
    add_cfg(mbwb_pkg::CFG_FORE_COLOR, 16'hF800);
    add_cfg(mbwb_pkg::CFG_BACK_COLOR, 16'h07E0);
    add_item(mbwb_pkg::OP_START, 8'h00);
    add_item(mbwb_pkg::OP_BYTE, 8'h80);
    add_item(mbwb_pkg::OP_BYTE, 8'h40);
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'd20);
    add_cfg(mbwb_pkg::CFG_FORE_COLOR, 16'h001F);
    add_item(mbwb_pkg::OP_BYTE, 8'h20);
    add_item(mbwb_pkg::OP_BYTE, 8'hE0);
    // Partial last byte per row, and a restart in the middle of a frame.
    add_cfg(mbwb_pkg::CFG_CENTER_MODE, 16'd0);
    add_cfg(mbwb_pkg::CFG_POS_X, 16'd100);
    add_cfg(mbwb_pkg::CFG_POS_Y, 16'd200);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'd3);
    add_item(mbwb_pkg::OP_START, 8'h00);
    add_item(mbwb_pkg::OP_BYTE, 8'hC3);
    add_item(mbwb_pkg::OP_START, 8'hFF);
    add_item(mbwb_pkg::OP_BYTE, 8'h81);
    add_item(mbwb_pkg::OP_BYTE, 8'h7E);
    add_item(mbwb_pkg::OP_BYTE, 8'hFF);
    add_item(mbwb_pkg::OP_BYTE, 8'h01);
    // Empty by width, then empty by height.
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'd0);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'd5);
    add_item(mbwb_pkg::OP_START, 8'h00);
    add_item(mbwb_pkg::OP_BYTE, 8'h33);
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'd9);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'd0);
    add_item(mbwb_pkg::OP_START, 8'h00);
    // Largest centered image.
    add_cfg(mbwb_pkg::CFG_CENTER_MODE, 16'd1);
    add_cfg(mbwb_pkg::CFG_IMG_WIDTH, 16'hFFFF);
    add_cfg(mbwb_pkg::CFG_IMG_HEIGHT, 16'hFFFF);
    add_cfg(mbwb_pkg::CFG_POS_X, 16'h8000);
    add_cfg(mbwb_pkg::CFG_POS_Y, 16'h7FFF);
    add_typed(mbwb_pkg::OP_START, 8'h00, 4'd7, 1'b0,
              {mbwb_pkg::CMD_COLUMN_ADDR, 16'h0001, 16'hFFFF,
               mbwb_pkg::CMD_PAGE_ADDR, 16'h0000, 16'hFFFE,
               mbwb_pkg::CMD_MEM_WRITE, 16'h0000});
    add_item(mbwb_pkg::OP_BYTE, 8'h96);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) begin
          in_ch.valid <= 1'b0;
          wait_drained();
        end
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        cfg_ch.valid <= 1'b0;
        send_item(plan[i].op, plan[i].bits, i);
      end
    end

    // Random frames: mostly complete images, some cut short or restarted.
    n_items = 0;
    phase = 0;
    while (n_items < RAND_ITEMS) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      no_idle = ($urandom_range(0, 5) == 0);
      sel = $urandom_range(0, 19);
      center = 1'($urandom_range(0, 1));
      if (phase == 3) begin
        w = 40;
        h = 6;
      end else if (sel == 0) begin
        w = 0;
        h = $urandom_range(1, 4);
      end else if (sel == 1) begin
        w = $urandom_range(1, 20);
        h = 0;
      end else if (sel == 2) begin
        w = 65535;
        h = 65535;
      end else if (sel == 3) begin
        w = 1;
        h = $urandom_range(1, 5);
      end else begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 6);
      end
      cfg_write(mbwb_pkg::CFG_POS_X, pick_word());
      cfg_write(mbwb_pkg::CFG_POS_Y, pick_word());
      cfg_write(mbwb_pkg::CFG_IMG_WIDTH, 16'(w));
      cfg_write(mbwb_pkg::CFG_IMG_HEIGHT, 16'(h));
      cfg_write(mbwb_pkg::CFG_FORE_COLOR, pick_word());
      cfg_write(mbwb_pkg::CFG_BACK_COLOR, pick_word());
      cfg_write(mbwb_pkg::CFG_CENTER_MODE, {15'd0, center});
      cfg_ch.valid <= 1'b0;

      if (w == 0 || h == 0) nbytes = 0;
      else if (w == 65535) nbytes = $urandom_range(2, 6);
      else nbytes = ((w + 7) / 8) * h;
      restart_at = -1;
      if (phase != 3) begin
        r = $urandom_range(0, 9);
        if (r == 0) nbytes = $urandom_range(0, nbytes);
        else if (r == 1) restart_at = $urandom_range(0, nbytes);
      end
      fill = ($urandom_range(0, 4) == 0);
      // The receiver holds off while this frame's bytes keep coming.
      if (phase == 3) hold_req = 1'b1;

      send_item(mbwb_pkg::OP_START, 8'($urandom_range(0, 255)), -1);
      n_items++;
      for (k = 0; k < nbytes; k++) begin
        if (k == restart_at) begin
          send_item(mbwb_pkg::OP_START, 8'($urandom_range(0, 255)), -1);
          n_items++;
        end
        send_item(mbwb_pkg::OP_BYTE, fill ? 8'hFF : 8'($urandom_range(0, 255)), -1);
        n_items++;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(mbwb_pkg::OP_BYTE, 8'($urandom_range(0, 255)), -1);
          n_items++;
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
